// ----- rtl/pe_pkg.sv -----
// Shared types and constants for the polynomial evaluator.
// Used by the channel interfaces, the Horner step and the top level.
package pe_pkg;

  // word and register widths
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DEGREE_W    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // defaults for the top-level parameters
  localparam int MAX_DEGREE_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_DEGREE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_BASE = 3'd1;

  // saturation limits
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // word carried from one Horner step to the next
  typedef struct packed {
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] x;
    logic                     ovf;
  } pe_word_t;

endpackage

// ----- rtl/pe_ifs.sv -----
// Valid/ready channel interfaces for the polynomial evaluator.
// Depends on pe_pkg for the data width.
interface pe_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [pe_pkg::DATA_W-1:0] sample_x;

  modport source(output valid, output sample_x, input ready);
  modport sink(input valid, input sample_x, output ready);
endinterface

interface pe_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [pe_pkg::DATA_W-1:0] poly_value;
  logic                             overflow;

  modport source(output valid, output poly_value, output overflow, input ready);
  modport sink(input valid, input poly_value, input overflow, output ready);
endinterface

// ----- rtl/pe_step.sv -----
// One Horner step: multiply stage, then floor shift, saturate, add, saturate.
// Two register stages with their own valid bits; depends on pe_pkg.
module pe_step #(
  parameter int FRAC_BITS = pe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             active,
  input  logic signed [pe_pkg::DATA_W-1:0] coef,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pe_pkg::pe_word_t                 in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pe_pkg::pe_word_t                 out_word
);

  localparam int DW = pe_pkg::DATA_W;
  localparam int PW = pe_pkg::PROD_W;

  logic                   a_valid;
  logic                   a_ready;
  logic signed [PW-1:0]   a_prod;
  pe_pkg::pe_word_t       a_word;

  logic                   b_valid;
  logic                   b_ready;
  pe_pkg::pe_word_t       b_word;
  pe_pkg::pe_word_t       b_word_next;

  logic signed [PW-1:0]   shifted;
  logic                   prod_fits;
  logic signed [DW-1:0]   q;
  logic signed [DW:0]     sum;
  logic                   sum_fits;
  logic signed [DW-1:0]   sum_sat;

  // stage ready: empty or draining downstream
  assign a_ready  = !a_valid || b_ready;
  assign b_ready  = !b_valid || out_ready;
  assign in_ready = a_ready;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_prod <= $signed(in_word.acc) * $signed(in_word.x);
      a_word <= in_word;
    end
  end

  // floor shift and product saturation
  always_comb begin
    shifted   = a_prod >>> FRAC_BITS;
    prod_fits = (shifted[PW-1:DW-1] == {(PW-DW+1){shifted[DW-1]}});
    if (prod_fits) begin
      q = shifted[DW-1:0];
    end else if (shifted[PW-1]) begin
      q = pe_pkg::S32_MIN;
    end else begin
      q = pe_pkg::S32_MAX;
    end
  end

  // coefficient add and sum saturation
  always_comb begin
    sum      = {q[DW-1], q} + {coef[DW-1], coef};
    sum_fits = (sum[DW] == sum[DW-1]);
    if (sum_fits) begin
      sum_sat = sum[DW-1:0];
    end else if (sum[DW]) begin
      sum_sat = pe_pkg::S32_MIN;
    end else begin
      sum_sat = pe_pkg::S32_MAX;
    end
  end

  // steps above the degree in use pass the accumulator through
  always_comb begin
    b_word_next   = a_word;
    if (active) begin
      b_word_next.acc = sum_sat;
      b_word_next.ovf = a_word.ovf | !prod_fits | !sum_fits;
    end
  end

  // add stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_word <= b_word_next;
    end
  end

  assign out_valid = b_valid;
  assign out_word  = b_word;

endmodule

// ----- rtl/polynomial_evaluator_core.sv -----
// Channel     Dir  Payload                     Handshake
// sample      in   sample_x (s32 Q16.16)       valid / ready
// result      out  poly_value (s32), overflow  valid / ready
// cfg         in   cfg_index, cfg_wdata        cfg_wr_en, no wait
//
// One sample enters per cycle while no stall reaches the input; each Horner step
// has one multiply stage and one add stage, and every step is passed whatever degree is in use.
// Synchronous active-high reset empties the pipeline, sets the degree to one
// and clears the coefficients.
// Each stage holds its word while the next one is full and stalled, so a
// bubble anywhere lets a new sample in while a result waits at the output.
module polynomial_evaluator_core #(
  parameter int MAX_DEGREE = pe_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = pe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  pe_sample_if.sink                        sample,
  pe_result_if.source                      result,
  input  logic                             cfg_wr_en,
  input  logic [pe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DW    = pe_pkg::DATA_W;
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);

  logic [DEG_W-1:0]              d_eff;
  logic signed [DW-1:0]          coefs [0:MAX_DEGREE];
  logic [pe_pkg::DEGREE_W-1:0]   raw_degree;

  logic                          v [0:MAX_DEGREE];
  logic                          r [0:MAX_DEGREE];
  pe_pkg::pe_word_t              w [0:MAX_DEGREE];

  assign raw_degree = cfg_wdata[pe_pkg::DEGREE_W-1:0];

  // configuration registers, degree clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      d_eff <= DEG_W'(1);
      for (int j = 0; j <= MAX_DEGREE; j++) begin
        coefs[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == pe_pkg::REG_DEGREE) begin
        if (raw_degree == '0) begin
          d_eff <= DEG_W'(1);
        end else if (raw_degree > pe_pkg::DEGREE_W'(MAX_DEGREE)) begin
          d_eff <= DEG_W'(MAX_DEGREE);
        end else begin
          d_eff <= DEG_W'(raw_degree);
        end
      end
      for (int j = 0; j <= MAX_DEGREE; j++) begin
        if (cfg_index == pe_pkg::CFG_INDEX_W'(int'(pe_pkg::REG_COEF_BASE) + j)) begin
          coefs[j] <= $signed(cfg_wdata[DW-1:0]);
        end
      end
    end
  end

  // entry word: accumulator starts at the leading coefficient
  assign w[0]         = '{acc: coefs[d_eff], x: sample.sample_x, ovf: 1'b0};
  assign v[0]         = sample.valid;
  assign sample.ready = r[0];

  // Horner steps, highest coefficient index first
  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
    localparam int CI = MAX_DEGREE - 1 - k;
    logic step_active;

    assign step_active = (DEG_W'(CI) < d_eff);

    pe_step #(
      .FRAC_BITS(FRAC_BITS)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .active   (step_active),
      .coef     (coefs[CI]),
      .in_valid (v[k]),
      .in_ready (r[k]),
      .in_word  (w[k]),
      .out_valid(v[k+1]),
      .out_ready(r[k+1]),
      .out_word (w[k+1])
    );
  end

  // result channel straight from the last stage register
  assign result.valid      = v[MAX_DEGREE];
  assign result.poly_value = w[MAX_DEGREE].acc;
  assign result.overflow   = w[MAX_DEGREE].ovf;
  assign r[MAX_DEGREE]     = result.ready;

`ifndef SYNTHESIS
  // degree in use always within range
  assert property (@(posedge clk) disable iff (rst)
    d_eff != '0 && d_eff <= DEG_W'(MAX_DEGREE))
    else $error("degree in use out of range");

  // input back-pressure only comes from a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (result.valid && !result.ready))
    else $error("input stalled with no stalled result");

  // pipeline empty right after reset
  assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid after reset");
`endif

endmodule
